>>> hw/rtl/lmi_pkg.sv
`timescale 1ns / 1ps

package lmi_pkg;

  // coordinate, difference, cross-product, dot-product and datapath widths
  localparam int CW = 32;
  localparam int DW = CW + 1;
  localparam int NW = 68;
  localparam int SW = 104;
  localparam int WB = 144;

  // point quotient: magnitude limit 2^QBITS, signed result QW bits
  localparam int QBITS = 37;
  localparam int QW = QBITS + 2;
  localparam int SUMW = QW + 1;

  // shift-add multiplier walks a DW-bit signed multiplier
  localparam int MUL_STEPS = DW;
  localparam int BCW = 6;

  localparam int UCODE_LEN = 30;
  localparam int UPCW = 5;

  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_VERTICAL = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] origin_x;
    logic signed [CW-1:0] origin_y;
    logic signed [CW-1:0] origin_z;
    logic signed [CW-1:0] dir_x;
    logic signed [CW-1:0] dir_y;
    logic signed [CW-1:0] dir_z;
    logic                 vertical_mode;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
    logic                 last_face;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    logic                 is_hit;
    logic                 mesh_done;
  } result_t;

  // classified face: edge vectors u, v and origin offset w
  typedef struct packed {
    logic [2:0][DW-1:0] u;
    logic [2:0][DW-1:0] v;
    logic [2:0][DW-1:0] w;
    logic               skip;
    logic               last_face;
  } face_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [3:0] {
    M_U0, M_U1, M_U2, M_V0, M_V1, M_V2, M_W0, M_W1, M_W2,
    M_N0, M_N1, M_N2, M_X0, M_X1, M_X2
  } msrc_e;

  typedef enum logic [3:0] {
    Q_U0, Q_U1, Q_U2, Q_V0, Q_V1, Q_V2, Q_W0, Q_W1, Q_W2,
    Q_D0, Q_D1, Q_D2
  } qsrc_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_N0, DST_N1, DST_N2, DST_X0, DST_X1, DST_X2,
    DST_B, DST_NA, DST_S, DST_T
  } dst_e;

  typedef struct packed {
    msrc_e m;
    qsrc_e q;
    logic  sub;
    logic  clr;
    dst_e  dst;
  } uop_t;

  function automatic uop_t mk(msrc_e m, qsrc_e q, logic sub, logic clr, dst_e dst);
    uop_t r;
    r.m = m;
    r.q = q;
    r.sub = sub;
    r.clr = clr;
    r.dst = dst;
    return r;
  endfunction

  // n = u x v, b = n.d, na = n.w, x = v x d, s = w.x, x = w x d, t = u.x
  function automatic uop_t ucode(logic [UPCW-1:0] pc);
    uop_t r;
    unique case (pc)
      5'd0:  r = mk(M_U1, Q_V2, 1'b0, 1'b1, DST_NONE);
      5'd1:  r = mk(M_U2, Q_V1, 1'b1, 1'b0, DST_N0);
      5'd2:  r = mk(M_U2, Q_V0, 1'b0, 1'b1, DST_NONE);
      5'd3:  r = mk(M_U0, Q_V2, 1'b1, 1'b0, DST_N1);
      5'd4:  r = mk(M_U0, Q_V1, 1'b0, 1'b1, DST_NONE);
      5'd5:  r = mk(M_U1, Q_V0, 1'b1, 1'b0, DST_N2);
      5'd6:  r = mk(M_N0, Q_D0, 1'b0, 1'b1, DST_NONE);
      5'd7:  r = mk(M_N1, Q_D1, 1'b0, 1'b0, DST_NONE);
      5'd8:  r = mk(M_N2, Q_D2, 1'b0, 1'b0, DST_B);
      5'd9:  r = mk(M_N0, Q_W0, 1'b0, 1'b1, DST_NONE);
      5'd10: r = mk(M_N1, Q_W1, 1'b0, 1'b0, DST_NONE);
      5'd11: r = mk(M_N2, Q_W2, 1'b0, 1'b0, DST_NA);
      5'd12: r = mk(M_V1, Q_D2, 1'b0, 1'b1, DST_NONE);
      5'd13: r = mk(M_V2, Q_D1, 1'b1, 1'b0, DST_X0);
      5'd14: r = mk(M_V2, Q_D0, 1'b0, 1'b1, DST_NONE);
      5'd15: r = mk(M_V0, Q_D2, 1'b1, 1'b0, DST_X1);
      5'd16: r = mk(M_V0, Q_D1, 1'b0, 1'b1, DST_NONE);
      5'd17: r = mk(M_V1, Q_D0, 1'b1, 1'b0, DST_X2);
      5'd18: r = mk(M_X0, Q_W0, 1'b0, 1'b1, DST_NONE);
      5'd19: r = mk(M_X1, Q_W1, 1'b0, 1'b0, DST_NONE);
      5'd20: r = mk(M_X2, Q_W2, 1'b0, 1'b0, DST_S);
      5'd21: r = mk(M_W1, Q_D2, 1'b0, 1'b1, DST_NONE);
      5'd22: r = mk(M_W2, Q_D1, 1'b1, 1'b0, DST_X0);
      5'd23: r = mk(M_W2, Q_D0, 1'b0, 1'b1, DST_NONE);
      5'd24: r = mk(M_W0, Q_D2, 1'b1, 1'b0, DST_X1);
      5'd25: r = mk(M_W0, Q_D1, 1'b0, 1'b1, DST_NONE);
      5'd26: r = mk(M_W1, Q_D0, 1'b1, 1'b0, DST_X2);
      5'd27: r = mk(M_X0, Q_U0, 1'b0, 1'b1, DST_NONE);
      5'd28: r = mk(M_X1, Q_U1, 1'b0, 1'b0, DST_NONE);
      5'd29: r = mk(M_X2, Q_U2, 1'b0, 1'b0, DST_T);
      default: r = mk(M_U0, Q_U0, 1'b0, 1'b0, DST_NONE);
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/lmi_front.sv
`timescale 1ns / 1ps

module lmi_front (
  input  lmi_pkg::item_t item,
  input  lmi_pkg::cfg_t  cfg,
  output lmi_pkg::face_t face
);

  logic signed [lmi_pkg::CW-1:0] min_x, max_x, min_y, max_y;
  logic out_x, out_y;

  function automatic logic signed [lmi_pkg::DW-1:0] diff(
    logic signed [lmi_pkg::CW-1:0] p, logic signed [lmi_pkg::CW-1:0] q);
    return lmi_pkg::DW'(p) - lmi_pkg::DW'(q);
  endfunction

  always_comb begin
    min_x = (item.a_x < item.b_x) ? item.a_x : item.b_x;
    min_x = (item.c_x < min_x) ? item.c_x : min_x;
    max_x = (item.a_x > item.b_x) ? item.a_x : item.b_x;
    max_x = (item.c_x > max_x) ? item.c_x : max_x;
    min_y = (item.a_y < item.b_y) ? item.a_y : item.b_y;
    min_y = (item.c_y < min_y) ? item.c_y : min_y;
    max_y = (item.a_y > item.b_y) ? item.a_y : item.b_y;
    max_y = (item.c_y > max_y) ? item.c_y : max_y;
    out_x = (cfg.origin_x < min_x) || (cfg.origin_x > max_x);
    out_y = (cfg.origin_y < min_y) || (cfg.origin_y > max_y);

    face.u[0] = diff(item.b_x, item.a_x);
    face.u[1] = diff(item.b_y, item.a_y);
    face.u[2] = diff(item.b_z, item.a_z);
    face.v[0] = diff(item.c_x, item.a_x);
    face.v[1] = diff(item.c_y, item.a_y);
    face.v[2] = diff(item.c_z, item.a_z);
    face.w[0] = diff(cfg.origin_x, item.a_x);
    face.w[1] = diff(cfg.origin_y, item.a_y);
    face.w[2] = diff(cfg.origin_z, item.a_z);
    face.skip = cfg.vertical_mode & (out_x | out_y);
    face.last_face = item.last_face;
  end

endmodule

>>> hw/rtl/lmi_queue.sv
`timescale 1ns / 1ps

module lmi_queue #(
  parameter int DEPTH = lmi_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lmi_pkg::face_t     wr_data,
  input  logic               pop,
  output lmi_pkg::face_t     rd_data,
  output lmi_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  lmi_pkg::face_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;

  function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  assign rd_data = mem[rd_ptr];
  assign status.full = (count == CNTW'(DEPTH));
  assign status.empty = (count == '0);

endmodule

>>> hw/rtl/lmi_back.sv
`timescale 1ns / 1ps

module lmi_back (
  input  logic                clk,
  input  logic                rst,
  input  lmi_pkg::face_t      head,
  input  logic                q_empty,
  output logic                pop,
  input  lmi_pkg::cfg_t       cfg,
  output logic                result_valid,
  input  logic                result_stall,
  output lmi_pkg::result_t    result
);

  localparam int WB = lmi_pkg::WB;
  localparam int DW = lmi_pkg::DW;
  localparam int NW = lmi_pkg::NW;
  localparam int SW = lmi_pkg::SW;
  localparam int CW = lmi_pkg::CW;
  localparam int QW = lmi_pkg::QW;
  localparam int QBITS = lmi_pkg::QBITS;
  localparam int SUMW = lmi_pkg::SUMW;
  localparam int BCW = lmi_pkg::BCW;
  localparam int UPCW = lmi_pkg::UPCW;
  localparam logic signed [QW-1:0] QLIM = {2'b01, {QBITS{1'b0}}};

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MLOAD  = 11'b000_0000_0010,
    S_MUL    = 11'b000_0000_0100,
    S_NORM   = 11'b000_0000_1000,
    S_DECIDE = 11'b000_0001_0000,
    S_PLOAD  = 11'b000_0010_0000,
    S_DPRE   = 11'b000_0100_0000,
    S_DABS   = 11'b000_1000_0000,
    S_DCHK   = 11'b001_0000_0000,
    S_DLOOP  = 11'b010_0000_0000,
    S_DFIN   = 11'b100_0000_0000
  } state_t;

  state_t state;
  logic emit;
  logic emit_now;

  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] w [3];
  logic last, report, pt_phase;
  logic [1:0] hits_found;

  logic signed [NW-1:0] n [3];
  logic signed [NW-1:0] x [3];
  logic signed [SW-1:0] b, na, s, t, aeff;

  // shared shift-add multiplier
  logic [UPCW-1:0] upc;
  lmi_pkg::uop_t uop;
  logic usub;
  lmi_pkg::dst_e udst;
  logic [BCW-1:0] bitcnt;
  logic signed [WB-1:0] acc, msh, acc_nx;
  logic signed [DW-1:0] qreg;
  logic signed [WB-1:0] mval;
  logic signed [DW-1:0] qval;

  // restoring divider for the point
  logic signed [WB-1:0] r;
  logic [WB-1:0] m, den, dsh;
  logic rneg, qsat;
  logic [QBITS-1:0] q;
  logic [1:0] axis;
  logic signed [CW-1:0] hp [3];
  logic signed [CW-1:0] osel;
  logic signed [CW-1:0] dsel;
  logic signed [QW-1:0] qpos, qsig;
  logic signed [SUMW-1:0] sum;
  logic signed [CW-1:0] hp_nx;
  logic signed [SW-1:0] margin;
  logic out_free;

  assign uop = lmi_pkg::ucode(upc);
  assign out_free = !result_valid || !result_stall;
  assign pop = (state == S_IDLE) && !emit && !q_empty;
  assign emit_now = (state == S_IDLE) && emit && (report || last) && out_free;

  always_comb begin
    case (uop.m)
      lmi_pkg::M_U0: mval = WB'(u[0]);
      lmi_pkg::M_U1: mval = WB'(u[1]);
      lmi_pkg::M_U2: mval = WB'(u[2]);
      lmi_pkg::M_V0: mval = WB'(v[0]);
      lmi_pkg::M_V1: mval = WB'(v[1]);
      lmi_pkg::M_V2: mval = WB'(v[2]);
      lmi_pkg::M_W0: mval = WB'(w[0]);
      lmi_pkg::M_W1: mval = WB'(w[1]);
      lmi_pkg::M_W2: mval = WB'(w[2]);
      lmi_pkg::M_N0: mval = WB'(n[0]);
      lmi_pkg::M_N1: mval = WB'(n[1]);
      lmi_pkg::M_N2: mval = WB'(n[2]);
      lmi_pkg::M_X0: mval = WB'(x[0]);
      lmi_pkg::M_X1: mval = WB'(x[1]);
      lmi_pkg::M_X2: mval = WB'(x[2]);
      default:       mval = '0;
    endcase
    case (uop.q)
      lmi_pkg::Q_U0: qval = u[0];
      lmi_pkg::Q_U1: qval = u[1];
      lmi_pkg::Q_U2: qval = u[2];
      lmi_pkg::Q_V0: qval = v[0];
      lmi_pkg::Q_V1: qval = v[1];
      lmi_pkg::Q_V2: qval = v[2];
      lmi_pkg::Q_W0: qval = w[0];
      lmi_pkg::Q_W1: qval = w[1];
      lmi_pkg::Q_W2: qval = w[2];
      lmi_pkg::Q_D0: qval = DW'(cfg.dir_x);
      lmi_pkg::Q_D1: qval = DW'(cfg.dir_y);
      lmi_pkg::Q_D2: qval = DW'(cfg.dir_z);
      default:       qval = '0;
    endcase
    case (axis)
      2'd0:    begin osel = cfg.origin_x; dsel = cfg.dir_x; end
      2'd1:    begin osel = cfg.origin_y; dsel = cfg.dir_y; end
      default: begin osel = cfg.origin_z; dsel = cfg.dir_z; end
    endcase
  end

  // top multiplier bit carries negative weight
  always_comb begin
    if (!qreg[0]) begin
      acc_nx = acc;
    end else if (usub ^ (bitcnt == BCW'(lmi_pkg::MUL_STEPS - 1))) begin
      acc_nx = acc - msh;
    end else begin
      acc_nx = acc + msh;
    end
  end

  always_comb begin
    margin = b - s - t;
    qpos = $signed({2'b00, q});
    if (qsat) begin
      qsig = rneg ? -QLIM : QLIM;
    end else if (rneg) begin
      qsig = -qpos - $signed({{(QW-1){1'b0}}, (m != '0)});
    end else begin
      qsig = qpos;
    end
    sum = SUMW'(osel) + SUMW'(qsig);
    if (sum[SUMW-1:CW-1] != '0 && sum[SUMW-1:CW-1] != '1) begin
      hp_nx = sum[SUMW-1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      hp_nx = sum[CW-1:0];
    end
  end

  // output word valid: set on emit, dropped once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_now) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      emit <= 1'b0;
      hits_found <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (emit) begin
            if (!(report || last)) begin
              emit <= 1'b0;
            end else if (out_free) begin
              emit <= 1'b0;
              result.hit_x <= report ? hp[0] : '0;
              result.hit_y <= report ? hp[1] : '0;
              result.hit_z <= report ? hp[2] : '0;
              result.is_hit <= report;
              result.mesh_done <= last;
            end
            if (!(report || last) || out_free) begin
              if (last) begin
                hits_found <= '0;
              end else if (report) begin
                hits_found <= hits_found + 2'd1;
              end
            end
          end else if (!q_empty) begin
            for (int i = 0; i < 3; i++) begin
              u[i] <= $signed(head.u[i]);
              v[i] <= $signed(head.v[i]);
              w[i] <= $signed(head.w[i]);
            end
            last <= head.last_face;
            report <= 1'b0;
            upc <= '0;
            pt_phase <= 1'b0;
            if (head.skip) begin
              emit <= 1'b1;
            end else begin
              state <= S_MLOAD;
            end
          end
        end
        S_MLOAD: begin
          msh <= mval;
          qreg <= qval;
          usub <= uop.sub;
          udst <= uop.dst;
          bitcnt <= '0;
          if (uop.clr) begin
            acc <= '0;
          end
          state <= S_MUL;
        end
        S_PLOAD: begin
          msh <= WB'(aeff);
          qreg <= DW'(dsel);
          usub <= 1'b0;
          udst <= lmi_pkg::DST_NONE;
          bitcnt <= '0;
          acc <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= acc_nx;
          msh <= msh <<< 1;
          qreg <= qreg >>> 1;
          bitcnt <= bitcnt + BCW'(1);
          if (bitcnt == BCW'(lmi_pkg::MUL_STEPS - 1)) begin
            case (udst)
              lmi_pkg::DST_N0: n[0] <= acc_nx[NW-1:0];
              lmi_pkg::DST_N1: n[1] <= acc_nx[NW-1:0];
              lmi_pkg::DST_N2: n[2] <= acc_nx[NW-1:0];
              lmi_pkg::DST_X0: x[0] <= acc_nx[NW-1:0];
              lmi_pkg::DST_X1: x[1] <= acc_nx[NW-1:0];
              lmi_pkg::DST_X2: x[2] <= acc_nx[NW-1:0];
              lmi_pkg::DST_B:  b <= acc_nx[SW-1:0];
              lmi_pkg::DST_NA: na <= acc_nx[SW-1:0];
              lmi_pkg::DST_S:  s <= acc_nx[SW-1:0];
              lmi_pkg::DST_T:  t <= acc_nx[SW-1:0];
              default: ;
            endcase
            if (pt_phase) begin
              state <= S_DPRE;
            end else if (upc == UPCW'(lmi_pkg::UCODE_LEN - 1)) begin
              state <= S_NORM;
            end else begin
              upc <= upc + UPCW'(1);
              state <= S_MLOAD;
            end
          end
        end
        S_NORM: begin
          // make b positive, a = -na
          if (b[SW-1]) begin
            b <= -b;
            aeff <= na;
            s <= -s;
            t <= -t;
          end else begin
            aeff <= -na;
          end
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (b != '0 && !s[SW-1] && !t[SW-1] && !margin[SW-1] && hits_found < 2'd2) begin
            report <= 1'b1;
            pt_phase <= 1'b1;
            axis <= '0;
            state <= S_PLOAD;
          end else begin
            emit <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DPRE: begin
          r <= (acc <<< 1) + WB'(b);
          state <= S_DABS;
        end
        S_DABS: begin
          rneg <= r[WB-1];
          m <= r[WB-1] ? -r : r;
          den <= WB'(b) << 1;
          state <= S_DCHK;
        end
        S_DCHK: begin
          qsat <= (m >= (den << QBITS));
          dsh <= den << (QBITS - 1);
          q <= '0;
          bitcnt <= '0;
          state <= (m >= (den << QBITS)) ? S_DFIN : S_DLOOP;
        end
        S_DLOOP: begin
          if (m >= dsh) begin
            m <= m - dsh;
          end
          q <= {q[QBITS-2:0], (m >= dsh)};
          dsh <= dsh >> 1;
          bitcnt <= bitcnt + BCW'(1);
          if (bitcnt == BCW'(QBITS - 1)) begin
            state <= S_DFIN;
          end
        end
        S_DFIN: begin
          hp[axis] <= hp_nx;
          if (axis == 2'd2) begin
            emit <= 1'b1;
            state <= S_IDLE;
          end else begin
            axis <= axis + 2'd1;
            state <= S_PLOAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/line_mesh_intersection.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                    Word
// item      in   item_valid / item_stall      lmi_pkg::item_t (triangle + last_face)
// result    out  result_valid / result_stall  lmi_pkg::result_t (point, is_hit, mesh_done)
// config    in   cfg_we, cfg_index, cfg_data  one register per write, no read-back
//
// Flow: the geometry engine runs 30 multiply steps on one shift-add unit for a
// tested face; a reported hit adds three point divisions, one per axis. A skipped
// face bypasses the geometry engine.
// Reset clears the hit count, the queue and the output valid flag; config resets to 0.
// The front keeps accepting into a short queue while the back waits on result_stall.

module line_mesh_intersection #(
  parameter int QUEUE_DEPTH = lmi_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  lmi_pkg::item_t                  item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output lmi_pkg::result_t                result,
  input  logic                            cfg_we,
  input  logic [lmi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lmi_pkg::CW-1:0]          cfg_data
);

  lmi_pkg::cfg_t cfg;
  lmi_pkg::face_t face, head;
  lmi_pkg::q_status_t qstat;
  logic push, pop;

  // configuration registers; writes past the list fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmi_pkg::REG_ORIGIN_X: cfg.origin_x <= cfg_data;
        lmi_pkg::REG_ORIGIN_Y: cfg.origin_y <= cfg_data;
        lmi_pkg::REG_ORIGIN_Z: cfg.origin_z <= cfg_data;
        lmi_pkg::REG_DIR_X:    cfg.dir_x <= cfg_data;
        lmi_pkg::REG_DIR_Y:    cfg.dir_y <= cfg_data;
        lmi_pkg::REG_DIR_Z:    cfg.dir_z <= cfg_data;
        lmi_pkg::REG_VERTICAL: cfg.vertical_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: edge vectors and the vertical-mode range check
  lmi_front u_front (
    .item (item),
    .cfg  (cfg),
    .face (face)
  );

  assign item_stall = qstat.full;
  assign push = item_valid && !qstat.full;

  lmi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (face),
    .pop     (pop),
    .rd_data (head),
    .status  (qstat)
  );

  // back: exact plane test, hit count and rounded point
  lmi_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (qstat.empty),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
